[rtl/pfc_pkg.sv]
`default_nettype none

package pfc_pkg;

  localparam int unsigned LET_W   = 5;
  localparam int unsigned SQ_W    = 5;
  localparam int unsigned NUM_SQ  = 25;
  localparam int unsigned NUM_LET = 26;

  localparam logic [LET_W-1:0] LET_I    = 5'd8;
  localparam logic [LET_W-1:0] LET_J    = 5'd9;
  localparam logic [LET_W-1:0] LET_X    = 5'd23;
  localparam logic [LET_W-1:0] LET_Z    = 5'd25;
  localparam logic [LET_W-1:0] LET_LAST = 5'd25;
  localparam logic [SQ_W-1:0]  SQ_FULL  = 5'd25;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'd32;
  localparam logic [6:0] ASCII_A   = 7'd65;

  typedef enum logic [1:0] {
    OP_KEY_CHAR  = 2'd0,
    OP_KEY_DONE  = 2'd1,
    OP_TEXT_CHAR = 2'd2,
    OP_TEXT_END  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_PAIR,
    S_SLOT,
    S_EMIT_A,
    S_EMIT_B
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_char;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       pair_last;
  } out_item_t;

  typedef struct packed {
    logic             ok;
    logic [LET_W-1:0] code;
  } fold_t;

  // one write port shared by both arrays, two read ports on each
  typedef struct packed {
    logic             wr_en;
    logic [SQ_W-1:0]  wr_sq;
    logic [LET_W-1:0] wr_let;
    logic             slot_rd_en;
    logic [LET_W-1:0] slot_rd_a;
    logic [LET_W-1:0] slot_rd_b;
    logic             grid_rd_en;
    logic [SQ_W-1:0]  grid_rd_a;
    logic [SQ_W-1:0]  grid_rd_b;
  } store_req_t;

  function automatic fold_t fold_char(logic [7:0] raw);
    logic [7:0] c;
    fold_t      r;
    c = raw;
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      c = c - CASE_GAP;
    end
    r.ok   = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    r.code = LET_W'(c - CHAR_UP_A);
    if (r.code == LET_J) begin
      r.code = LET_I;
    end
    return r;
  endfunction

  function automatic logic [2:0] sq_row(logic [SQ_W-1:0] sq);
    logic [2:0] r;
    priority if (sq >= 5'd20) begin
      r = 3'd4;
    end else if (sq >= 5'd15) begin
      r = 3'd3;
    end else if (sq >= 5'd10) begin
      r = 3'd2;
    end else if (sq >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/pfc_store.sv]
`default_nettype none

module pfc_store (
  input  wire logic                       clk_i,
  input  wire pfc_pkg::store_req_t        req_i,
  output logic [pfc_pkg::SQ_W-1:0]        slot_a_o,
  output logic [pfc_pkg::SQ_W-1:0]        slot_b_o,
  output logic [pfc_pkg::LET_W-1:0]       grid_a_o,
  output logic [pfc_pkg::LET_W-1:0]       grid_b_o
);

  // grid: square -> letter, slot: letter -> square
  logic [pfc_pkg::LET_W-1:0] grid_mem [pfc_pkg::NUM_SQ];
  logic [pfc_pkg::SQ_W-1:0]  slot_mem [pfc_pkg::NUM_LET];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      grid_mem[req_i.wr_sq]  <= req_i.wr_let;
      slot_mem[req_i.wr_let] <= req_i.wr_sq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.slot_rd_en) begin
      slot_a_o <= slot_mem[req_i.slot_rd_a];
      slot_b_o <= slot_mem[req_i.slot_rd_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.grid_rd_en) begin
      grid_a_o <= grid_mem[req_i.grid_rd_a];
      grid_b_o <= grid_mem[req_i.grid_rd_b];
    end
  end

endmodule

`default_nettype wire

[rtl/pfc_rule.sv]
`default_nettype none

module pfc_rule (
  input  wire logic [pfc_pkg::SQ_W-1:0] sq_a_i,
  input  wire logic [pfc_pkg::SQ_W-1:0] sq_b_i,
  input  wire logic                     encrypt_i,
  output logic [pfc_pkg::SQ_W-1:0]      sq_a_o,
  output logic [pfc_pkg::SQ_W-1:0]      sq_b_o
);

  logic [2:0] row_a, row_b, col_a, col_b;

  function automatic logic [2:0] wrap_step(logic [2:0] v, logic fwd);
    logic [2:0] r;
    if (fwd) begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end else begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end
    return r;
  endfunction

  function automatic logic [pfc_pkg::SQ_W-1:0] sq_index(logic [2:0] r, logic [2:0] c);
    return pfc_pkg::SQ_W'({r, 2'b00}) + pfc_pkg::SQ_W'(r) + pfc_pkg::SQ_W'(c);
  endfunction

  always_comb begin
    row_a = pfc_pkg::sq_row(sq_a_i);
    row_b = pfc_pkg::sq_row(sq_b_i);
    col_a = 3'(sq_a_i - sq_index(row_a, 3'd0));
    col_b = 3'(sq_b_i - sq_index(row_b, 3'd0));
  end

  always_comb begin
    priority if (row_a == row_b) begin
      sq_a_o = sq_index(row_a, wrap_step(col_a, encrypt_i));
      sq_b_o = sq_index(row_b, wrap_step(col_b, encrypt_i));
    end else if (col_a == col_b) begin
      sq_a_o = sq_index(wrap_step(row_a, encrypt_i), col_a);
      sq_b_o = sq_index(wrap_step(row_b, encrypt_i), col_b);
    end else begin
      // rectangle: swap columns
      sq_a_o = sq_index(row_a, col_b);
      sq_b_o = sq_index(row_b, col_a);
    end
  end

endmodule

`default_nettype wire

[rtl/playfair_digraph_cipher_core.sv]
`default_nettype none

// Key character: taken and placed in idle. Key done on an open key: one letter of the
// alphabet checked and placed per cycle by the fill sweep through the grid memory.
// Text character or text end that closes a pair: states pair, slot, emit A (first letter),
// emit B (second letter, after any output stall), then idle; no new transaction is taken
// before the pair is out. Two dependent memory reads (slot, then grid) precede emit A.
// Reset: encrypt mode on, key open and empty, no pending letter; memories not cleared.
module playfair_digraph_cipher_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pfc_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pfc_pkg::out_item_t       out_data_o
);

  pfc_pkg::state_e state_q, state_d;
  pfc_pkg::op_e    op_q, op_d, in_op;

  logic [pfc_pkg::SQ_W-1:0]    fill_q, fill_d, fill_eff;
  logic                        key_closed_q, key_closed_d;
  logic [pfc_pkg::NUM_LET-1:0] used_q, used_d, used_eff;
  logic [pfc_pkg::LET_W-1:0]   pend_let_q, pend_let_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [pfc_pkg::LET_W-1:0]   let_q, let_d;
  logic                        let_ok_q, let_ok_d;
  logic [pfc_pkg::LET_W-1:0]   sweep_q, sweep_d;
  logic                        mode_q;

  pfc_pkg::fold_t      in_fold;
  pfc_pkg::store_req_t req;
  logic                in_acc, place_key, place_sweep, sweep_end;
  logic [pfc_pkg::SQ_W-1:0]  slot_a, slot_b, rule_a, rule_b;
  logic [pfc_pkg::LET_W-1:0] grid_a, grid_b, pair_b;

  pfc_store u_store (
    .clk_i    (clk_i),
    .req_i    (req),
    .slot_a_o (slot_a),
    .slot_b_o (slot_b),
    .grid_a_o (grid_a),
    .grid_b_o (grid_b)
  );

  pfc_rule u_rule (
    .sq_a_i    (slot_a),
    .sq_b_i    (slot_b),
    .encrypt_i (mode_q),
    .sq_a_o    (rule_a),
    .sq_b_o    (rule_b)
  );

  always_comb begin
    in_op   = pfc_pkg::op_e'(in_data_i.opcode);
    in_fold = pfc_pkg::fold_char(in_data_i.in_char);
    in_acc  = in_valid_i && (state_q == pfc_pkg::S_IDLE);
    // a key character after the key is closed starts from an empty key
    used_eff  = key_closed_q ? '0 : used_q;
    fill_eff  = key_closed_q ? '0 : fill_q;
    place_key = in_acc && (in_op == pfc_pkg::OP_KEY_CHAR) && in_fold.ok
             && !used_eff[in_fold.code] && (fill_eff < pfc_pkg::SQ_FULL);
    place_sweep = (state_q == pfc_pkg::S_CLOSE) && (sweep_q != pfc_pkg::LET_J)
               && !used_q[sweep_q] && (fill_q < pfc_pkg::SQ_FULL);
    sweep_end = (sweep_q == pfc_pkg::LET_LAST);
    pair_b    = (op_q == pfc_pkg::OP_TEXT_END) ? pfc_pkg::LET_Z :
                (pend_let_q == let_q)          ? pfc_pkg::LET_X : let_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfc_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            pfc_pkg::OP_KEY_CHAR: state_d = pfc_pkg::S_IDLE;
            pfc_pkg::OP_KEY_DONE: state_d = key_closed_q ? pfc_pkg::S_IDLE
                                                         : pfc_pkg::S_CLOSE;
            pfc_pkg::OP_TEXT_CHAR,
            pfc_pkg::OP_TEXT_END: state_d = key_closed_q ? pfc_pkg::S_PAIR
                                                         : pfc_pkg::S_CLOSE;
          endcase
        end
      end
      pfc_pkg::S_CLOSE: begin
        if (sweep_end) begin
          state_d = (op_q == pfc_pkg::OP_KEY_DONE) ? pfc_pkg::S_IDLE : pfc_pkg::S_PAIR;
        end
      end
      pfc_pkg::S_PAIR: begin
        if (!pend_valid_q || (op_q == pfc_pkg::OP_TEXT_CHAR && !let_ok_q)) begin
          state_d = pfc_pkg::S_IDLE;
        end else begin
          state_d = pfc_pkg::S_SLOT;
        end
      end
      pfc_pkg::S_SLOT: state_d = pfc_pkg::S_EMIT_A;
      pfc_pkg::S_EMIT_A: begin
        if (!out_stall_i) begin
          state_d = pfc_pkg::S_EMIT_B;
        end
      end
      pfc_pkg::S_EMIT_B: begin
        if (!out_stall_i) begin
          state_d = pfc_pkg::S_IDLE;
        end
      end
      default: state_d = pfc_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    fill_d       = fill_q;
    key_closed_d = key_closed_q;
    used_d       = used_q;
    pend_let_d   = pend_let_q;
    pend_valid_d = pend_valid_q;
    op_d         = op_q;
    let_d        = let_q;
    let_ok_d     = let_ok_q;
    sweep_d      = sweep_q;
    unique case (state_q)
      pfc_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d     = in_op;
          let_d    = in_fold.code;
          let_ok_d = in_fold.ok;
          sweep_d  = '0;
          if (in_op == pfc_pkg::OP_KEY_CHAR && key_closed_q) begin
            fill_d       = '0;
            used_d       = '0;
            key_closed_d = 1'b0;
            pend_valid_d = 1'b0;
            pend_let_d   = '0;
          end
          if (place_key) begin
            fill_d                = fill_eff + pfc_pkg::SQ_W'(1);
            used_d                = used_eff;
            used_d[in_fold.code]  = 1'b1;
          end
        end
      end
      pfc_pkg::S_CLOSE: begin
        if (place_sweep) begin
          fill_d           = fill_q + pfc_pkg::SQ_W'(1);
          used_d[sweep_q]  = 1'b1;
        end
        if (sweep_end) begin
          key_closed_d = 1'b1;
        end else begin
          sweep_d = sweep_q + pfc_pkg::LET_W'(1);
        end
      end
      pfc_pkg::S_PAIR: begin
        if (op_q == pfc_pkg::OP_TEXT_CHAR) begin
          if (let_ok_q) begin
            pend_let_d = let_q;
            // a doubled letter stays open for the next pair
            pend_valid_d = !pend_valid_q || (pend_let_q == let_q);
          end
        end else begin
          pend_valid_d = 1'b0;
        end
      end
      pfc_pkg::S_SLOT, pfc_pkg::S_EMIT_A, pfc_pkg::S_EMIT_B: begin
      end
      default: begin
      end
    endcase
  end

  // outputs and memory requests
  always_comb begin
    in_stall_o           = (state_q != pfc_pkg::S_IDLE);
    out_valid_o          = (state_q == pfc_pkg::S_EMIT_A) || (state_q == pfc_pkg::S_EMIT_B);
    out_data_o.pair_last = (state_q == pfc_pkg::S_EMIT_B);
    out_data_o.out_char  = pfc_pkg::ASCII_A + 7'((state_q == pfc_pkg::S_EMIT_B) ? grid_b
                                                                                : grid_a);
    req            = '0;
    req.wr_en      = place_key || place_sweep;
    req.wr_sq      = (state_q == pfc_pkg::S_CLOSE) ? fill_q : fill_eff;
    req.wr_let     = (state_q == pfc_pkg::S_CLOSE) ? sweep_q : in_fold.code;
    req.slot_rd_en = (state_q == pfc_pkg::S_PAIR);
    req.slot_rd_a  = pend_let_q;
    req.slot_rd_b  = pair_b;
    req.grid_rd_en = (state_q == pfc_pkg::S_SLOT);
    req.grid_rd_a  = rule_a;
    req.grid_rd_b  = rule_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfc_pkg::S_IDLE;
      fill_q       <= '0;
      key_closed_q <= 1'b0;
      used_q       <= '0;
      pend_let_q   <= '0;
      pend_valid_q <= 1'b0;
      op_q         <= pfc_pkg::OP_KEY_CHAR;
      sweep_q      <= '0;
      mode_q       <= 1'b1;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      key_closed_q <= key_closed_d;
      used_q       <= used_d;
      pend_let_q   <= pend_let_d;
      pend_valid_q <= pend_valid_d;
      op_q         <= op_d;
      sweep_q      <= sweep_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    let_q    <= let_d;
    let_ok_q <= let_ok_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pfc_pkg::SQ_FULL)
    else $error("fill count beyond grid size");

  a_fill_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(fill_q))
    else $error("fill count out of step with used letters");

  a_close_fills_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfc_pkg::S_CLOSE && sweep_end) |=> (key_closed_q && fill_q == pfc_pkg::SQ_FULL))
    else $error("key close left grid incomplete");

  a_emit_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_closed_q && fill_q == pfc_pkg::SQ_FULL))
    else $error("output transaction with open key");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfc_pkg::S_EMIT_A && !out_stall_i) |=> (state_q == pfc_pkg::S_EMIT_B))
    else $error("second letter of digraph skipped");

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;   // longer than the key done sweep
  localparam int HOLD_LEN    = 300;
  localparam int ITEM_TARGET = 850;

  localparam int LT_I       = 8;
  localparam int LT_J       = 9;
  localparam int LT_X       = 23;
  localparam int LT_Z       = 25;
  localparam int NOT_LETTER = 26;
  localparam logic [6:0] CODE_A = 7'h41;

  typedef enum logic [1:0] {
    CMD_ITEM,
    CMD_DRAIN,
    CMD_CFG
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e         kind;
    pfc_pkg::in_item_t item;
    logic              mode;
  } stream_cmd_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  pfc_pkg::in_item_t  in_data_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  pfc_pkg::out_item_t out_data_o;

  playfair_digraph_cipher_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // cipher square as the block should hold it
  logic [4:0] sq_let [25];
  logic [4:0] let_sq [26];
  logic       let_placed [26];
  logic [4:0] n_placed;
  logic       square_done;
  logic [4:0] open_let;
  logic       open_ok;
  logic       enc_mode;

  stream_cmd_t        stream_q [$];
  pfc_pkg::out_item_t due_letters [$];

  int taken_n;
  int offered_n;
  int got_n;
  int miss_n;
  int cyc;
  int n_items;

  function automatic int letter_code(logic [7:0] raw);
    logic [7:0] u;
    int         l;
    u = raw;
    if (u >= "a" && u <= "z") begin
      u = u - 8'd32;
    end
    if (u < "A" || u > "Z") begin
      return NOT_LETTER;
    end
    l = int'(u - "A");
    if (l == LT_J) begin
      l = LT_I;
    end
    return l;
  endfunction

  task automatic place_in_square(int l);
    if (l < NOT_LETTER && !let_placed[l] && n_placed < 25) begin
      sq_let[n_placed] = 5'(l);
      let_sq[l]        = n_placed;
      let_placed[l]    = 1'b1;
      n_placed         = n_placed + 5'd1;
    end
  endtask

  task automatic finish_square();
    for (int l = 0; l < NOT_LETTER; l++) begin
      if (l != LT_J) begin
        place_in_square(l);
      end
    end
    square_done = 1'b1;
  endtask

  task automatic wipe_square();
    for (int i = 0; i < 25; i++) begin
      sq_let[i] = '0;
    end
    for (int l = 0; l < NOT_LETTER; l++) begin
      let_sq[l]     = '0;
      let_placed[l] = 1'b0;
    end
    n_placed    = '0;
    square_done = 1'b0;
    open_let    = '0;
    open_ok     = 1'b0;
  endtask

  task automatic push_digraph(int a, int b);
    int                 sa, sb, r1, c1, r2, c2, sh, oa, ob;
    pfc_pkg::out_item_t r;
    sa = int'(let_sq[a]);
    sb = int'(let_sq[b]);
    r1 = sa / 5;
    c1 = sa % 5;
    r2 = sb / 5;
    c2 = sb % 5;
    sh = enc_mode ? 1 : 4;
    if (r1 == r2) begin
      oa = r1 * 5 + (c1 + sh) % 5;
      ob = r2 * 5 + (c2 + sh) % 5;
    end else if (c1 == c2) begin
      oa = ((r1 + sh) % 5) * 5 + c1;
      ob = ((r2 + sh) % 5) * 5 + c2;
    end else begin
      oa = r1 * 5 + c2;
      ob = r2 * 5 + c1;
    end
    r.out_char  = CODE_A + 7'(sq_let[oa]);
    r.pair_last = 1'b0;
    due_letters.push_back(r);
    r.out_char  = CODE_A + 7'(sq_let[ob]);
    r.pair_last = 1'b1;
    due_letters.push_back(r);
  endtask

  task automatic predict_cipher(pfc_pkg::in_item_t it);
    int l;
    l = letter_code(it.in_char);
    case (pfc_pkg::op_e'(it.opcode))
      pfc_pkg::OP_KEY_CHAR: begin
        if (square_done) begin
          wipe_square();
        end
        place_in_square(l);
      end
      pfc_pkg::OP_KEY_DONE: begin
        if (!square_done) begin
          finish_square();
        end
      end
      pfc_pkg::OP_TEXT_CHAR: begin
        if (!square_done) begin
          finish_square();
        end
        if (l != NOT_LETTER) begin
          if (!open_ok) begin
            open_let = 5'(l);
            open_ok  = 1'b1;
          end else if (int'(open_let) == l) begin
            // doubled letter: pad with X, the new letter stays open
            push_digraph(l, LT_X);
          end else begin
            push_digraph(int'(open_let), l);
            open_ok = 1'b0;
          end
        end
      end
      default: begin
        if (!square_done) begin
          finish_square();
        end
        if (open_ok) begin
          push_digraph(int'(open_let), LT_Z);
          open_ok = 1'b0;
        end
      end
    endcase
  endtask

  task automatic add_item(pfc_pkg::op_e op, logic [7:0] c);
    stream_cmd_t e;
    e.kind         = CMD_ITEM;
    e.item.opcode  = op;
    e.item.in_char = c;
    e.mode         = 1'b0;
    stream_q.push_back(e);
    n_items++;
  endtask

  task automatic add_cfg(logic m);
    stream_cmd_t e;
    e.kind = CMD_DRAIN;
    e.item = '0;
    e.mode = 1'b0;
    stream_q.push_back(e);
    e.kind = CMD_CFG;
    e.mode = m;
    stream_q.push_back(e);
  endtask

  function automatic logic [7:0] pick_char(int noise_pct);
    logic [7:0] c;
    if ($urandom_range(0, 99) < noise_pct) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = 8'("A") + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) begin
        c = c | 8'h20;
      end
    end
    return c;
  endfunction

  // sample at the rising edge: predictions, result checks, timeout
  always @(posedge clk_i) begin : watch
    pfc_pkg::out_item_t want;
    if (rst_ni) begin
      cyc++;
      if (cfg_we_i) begin
        enc_mode = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        taken_n++;
        predict_cipher(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got_n++;
        if (due_letters.size() == 0) begin
          miss_n++;
          if (miss_n <= 10) begin
            $display("unexpected result %0d: char %h last %b", got_n,
                     out_data_o.out_char, out_data_o.pair_last);
          end
        end else begin
          want = due_letters.pop_front();
          if (out_data_o.out_char !== want.out_char ||
              out_data_o.pair_last !== want.pair_last) begin
            miss_n++;
            if (miss_n <= 10) begin
              $display("result %0d: expected char %h last %b, got char %h last %b", got_n,
                       want.out_char, want.pair_last,
                       out_data_o.out_char, out_data_o.pair_last);
            end
          end
        end
      end
      if (cyc >= CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // sender: bursts and gaps, drains and register writes from the stream
  int burst_left  = 0;
  int gap_left    = 0;
  int settle_left = 0;

  always @(negedge clk_i) begin : drive_feed
    logic              nxt_valid;
    pfc_pkg::in_item_t nxt_data;
    logic              nxt_we;
    logic              nxt_wd;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      nxt_we    = 1'b0;
      nxt_wd    = cfg_wdata_i;
      if (in_valid_i && taken_n == offered_n) begin
        void'(stream_q.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (stream_q.size() != 0) begin
          case (stream_q[0].kind)
            CMD_ITEM: begin
              nxt_valid = 1'b1;
              nxt_data  = stream_q[0].item;
              offered_n++;
              if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
              end else begin
                burst_left--;
              end
            end
            CMD_DRAIN: begin
              if (due_letters.size() == 0) begin
                settle_left = SETTLE;
                void'(stream_q.pop_front());
              end
            end
            default: begin
              nxt_we = 1'b1;
              nxt_wd = stream_q[0].mode;
              void'(stream_q.pop_front());
            end
          endcase
        end
      end
      in_valid_i  <= nxt_valid;
      in_data_i   <= nxt_data;
      cfg_we_i    <= nxt_we;
      cfg_wdata_i <= nxt_wd;
    end
  end

  // receiver: stall pattern by phase, plus long hold-offs keyed on result count
  int rcv_cyc      = 0;
  int hold_left    = 0;
  int next_hold_at = 60;

  always @(negedge clk_i) begin : drive_stall
    logic s;
    rcv_cyc++;
    if (hold_left > 0) begin
      s = 1'b1;
      hold_left--;
    end else if (got_n >= next_hold_at) begin
      s            = 1'b1;
      hold_left    = HOLD_LEN;
      next_hold_at = got_n + $urandom_range(150, 350);
    end else begin
      case ((rcv_cyc / 97) % 4)
        0:       s = 1'b0;
        1:       s = 1'($urandom_range(0, 1));
        2:       s = ($urandom_range(0, 3) != 0);
        default: s = (rcv_cyc % 3 == 0);
      endcase
    end
    out_stall_i <= s;
  end

  initial begin : run
    int         n_key;
    int         n_text;
    logic [7:0] c;
    logic [7:0] prev;
    enc_mode = 1'b1;
    wipe_square();

    // text before any key: square closes as plain alphabet
    add_item(pfc_pkg::OP_TEXT_CHAR, "h");
    add_item(pfc_pkg::OP_TEXT_CHAR, "e");
    // key after close wipes the square; J folds, repeats and junk drop
    add_item(pfc_pkg::OP_KEY_CHAR, "P");
    add_item(pfc_pkg::OP_KEY_CHAR, "l");
    add_item(pfc_pkg::OP_KEY_CHAR, "a");
    add_item(pfc_pkg::OP_KEY_CHAR, "J");
    add_item(pfc_pkg::OP_KEY_CHAR, "i");
    add_item(pfc_pkg::OP_KEY_CHAR, "#");
    add_item(pfc_pkg::OP_KEY_CHAR, 8'hFF);
    add_item(pfc_pkg::OP_KEY_CHAR, 8'h00);
    add_item(pfc_pkg::OP_KEY_DONE, 8'hFF);
    add_item(pfc_pkg::OP_KEY_DONE, 8'h00);
    add_item(pfc_pkg::OP_TEXT_CHAR, "l");
    add_item(pfc_pkg::OP_TEXT_CHAR, "L");
    add_item(pfc_pkg::OP_TEXT_CHAR, "o");
    add_item(pfc_pkg::OP_TEXT_CHAR, "x");
    add_item(pfc_pkg::OP_TEXT_CHAR, "X");
    add_item(pfc_pkg::OP_TEXT_END, 8'hAA);
    add_item(pfc_pkg::OP_TEXT_CHAR, "z");
    add_item(pfc_pkg::OP_TEXT_END, 8'h55);
    add_item(pfc_pkg::OP_TEXT_END, 8'h00);
    add_item(pfc_pkg::OP_TEXT_CHAR, "@");
    add_item(pfc_pkg::OP_TEXT_CHAR, "{");
    add_item(pfc_pkg::OP_TEXT_CHAR, 8'hC1);
    add_item(pfc_pkg::OP_TEXT_CHAR, "J");
    add_item(pfc_pkg::OP_TEXT_CHAR, "i");
    add_item(pfc_pkg::OP_TEXT_END, 8'hFF);
    add_cfg(1'b0);
    add_item(pfc_pkg::OP_TEXT_CHAR, "b");
    add_item(pfc_pkg::OP_TEXT_CHAR, "m");
    add_cfg(1'b1);

    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 1) begin
        add_cfg(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) < 8) begin
        // long keys now and then fill the whole square
        n_key = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 14);
        for (int k = 0; k < n_key; k++) begin
          add_item(pfc_pkg::OP_KEY_CHAR, pick_char(10));
        end
      end
      if ($urandom_range(0, 19) < 17) begin
        add_item(pfc_pkg::OP_KEY_DONE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
          add_item(pfc_pkg::OP_KEY_DONE, 8'($urandom_range(0, 255)));
        end
      end
      n_text = $urandom_range(2, 40);
      prev   = "A";
      for (int t = 0; t < n_text; t++) begin
        if ($urandom_range(0, 99) < 4) begin
          add_item(pfc_pkg::op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        c = ($urandom_range(0, 99) < 15) ? prev : pick_char(8);
        add_item(pfc_pkg::OP_TEXT_CHAR, c);
        prev = c;
      end
      if ($urandom_range(0, 9) < 8) begin
        add_item(pfc_pkg::OP_TEXT_END, 8'($urandom_range(0, 255)));
      end
    end
    add_item(pfc_pkg::OP_TEXT_END, 8'($urandom_range(0, 255)));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (stream_q.size() != 0 || in_valid_i || due_letters.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
    miss_n += due_letters.size();
    if (miss_n == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
